// File: src/vbpt_pkg.sv
package vbpt_pkg;

    // Item kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_ENABLE = 1'b1;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ON_TIME = 2'd3;

    // Register widths and reset values
    localparam int PERIOD_W = 16;
    localparam int ON_W     = 16;
    localparam int CCOUNT_W = 8;
    localparam int MAXON_W  = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd1000;
    localparam logic [ON_W-1:0]     ON_TIME_RST     = 16'd500;
    localparam logic [CCOUNT_W-1:0] CYCLE_COUNT_RST = 8'd1;
    localparam logic [MAXON_W-1:0]  MAX_ON_TIME_RST = 32'd10000;

    typedef struct packed {
        logic        kind;
        logic [15:0] elapsed;
        logic        enable_value;
    } item_t;

    typedef struct packed {
        logic valve_open;
        logic enabled;
        logic loop_end;
    } result_t;

endpackage

// File: src/valve_burst_pulse_timer.sv
// Valve burst pulse timer.
//
// Input channel (item_valid / item_ready / item): each word is either a time
// tick carrying the elapsed time units since the previous tick, or a request
// that writes the run enable flag. Output channel (result_valid /
// result_ready / result): exactly one word per input word, carrying the
// valve-open, enabled and loop-end flags after that word has been applied.
//
// The word is held in the input register, then the state update (one 16 x
// COUNT_WIDTH multiply for the cycle start, an add and a few compares)
// writes the result register when it advances, which raises result_valid.
// Throughput is one word per cycle while the receiver does not stall; the
// input register advances whenever the result register is empty or being
// emptied, so a stalled receiver holds at most two words inside before
// item_ready drops.
//
// Reset clears the run state, empties both stages and loads the register
// defaults (period 1000, on time 500, one cycle, max on time 10000).
// The configuration port writes one register per cycle with cfg_wr_en; write
// it only while no word is in flight.
module valve_burst_pulse_timer
    import vbpt_pkg::*;
#(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,

    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Product and compare widths; end of cycle needs one bit over the product
    localparam int PROD_W = PERIOD_W + COUNT_WIDTH + 1;
    localparam int AW     = (TIME_WIDTH > MAXON_W) ? TIME_WIDTH : MAXON_W;
    localparam int CMP_W  = (AW > PROD_W + 1) ? AW : PROD_W + 1;
    localparam int SUM_W  = TIME_WIDTH + 1;
    localparam int LW     = (COUNT_WIDTH > CCOUNT_W) ? COUNT_WIDTH : CCOUNT_W;

    // Configuration registers
    logic [PERIOD_W-1:0]    period_reg;
    logic [ON_W-1:0]        on_time_reg;
    logic [CCOUNT_W-1:0]    cycle_count_reg;
    logic [MAXON_W-1:0]     max_on_time_reg;

    // Run state
    logic                   run_en_reg,  run_en_next;
    logic                   open_reg,    open_next;
    logic                   cyc_end_reg, cyc_end_next;
    logic [TIME_WIDTH-1:0]  cot_reg,     cot_next;
    logic [COUNT_WIDTH-1:0] cdone_reg,   cdone_next;
    logic [TIME_WIDTH-1:0]  rtime_reg,   rtime_next;

    // Pipeline stages
    logic                   s1_valid_reg;
    item_t                  s1_item_reg;
    logic                   res_valid_reg;
    result_t                res_reg;

    logic                   advance;

    // Datapath
    logic [PROD_W-1:0]      start_w;
    logic [PROD_W-1:0]      end_w;
    logic [SUM_W-1:0]       rt_sum;
    logic [TIME_WIDTH-1:0]  rt_sat;
    logic [SUM_W-1:0]       cot_sum;
    logic [TIME_WIDTH-1:0]  cot_sat;
    logic [CCOUNT_W-1:0]    last_cycle;
    logic                   last_hit;
    logic                   shutdown;

    assign advance      = s1_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RST;
            on_time_reg     <= ON_TIME_RST;
            cycle_count_reg <= CYCLE_COUNT_RST;
            max_on_time_reg <= MAX_ON_TIME_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PERIOD:      period_reg      <= cfg_data[PERIOD_W-1:0];
                REG_ON_TIME:     on_time_reg     <= cfg_data[ON_W-1:0];
                REG_CYCLE_COUNT: cycle_count_reg <= cfg_data[CCOUNT_W-1:0];
                REG_MAX_ON_TIME: max_on_time_reg <= cfg_data[MAXON_W-1:0];
                default: ;
            endcase
        end
    end

    // Cycle window and saturating sums
    always_comb
    begin
        start_w    = PROD_W'(period_reg) * PROD_W'(cdone_reg);
        end_w      = start_w + PROD_W'(period_reg);
        rt_sum     = SUM_W'(rtime_reg) + SUM_W'(s1_item_reg.elapsed);
        rt_sat     = rt_sum[TIME_WIDTH] ? '1 : rt_sum[TIME_WIDTH-1:0];
        cot_sum    = SUM_W'(cot_reg) + SUM_W'(s1_item_reg.elapsed);
        cot_sat    = cot_sum[TIME_WIDTH] ? '1 : cot_sum[TIME_WIDTH-1:0];
        last_cycle = (cycle_count_reg == '0) ? '0 : cycle_count_reg - CCOUNT_W'(1);
        last_hit   = (LW'(cdone_reg) >= LW'(last_cycle)) || (&cdone_reg);
        shutdown   = (CMP_W'(cot_reg) >= CMP_W'(max_on_time_reg)) || !run_en_reg;
    end

    // State update for the word in the input register
    always_comb
    begin
        run_en_next  = run_en_reg;
        open_next    = open_reg;
        cyc_end_next = cyc_end_reg;
        cot_next     = cot_reg;
        cdone_next   = cdone_reg;
        rtime_next   = rtime_reg;

        if (advance)
        begin
            if (s1_item_reg.kind == KIND_ENABLE)
            begin
                // Only the flag; a disable bites at the next tick
                run_en_next = s1_item_reg.enable_value;
            end
            else if (shutdown)
            begin
                run_en_next  = 1'b0;
                open_next    = 1'b0;
                cyc_end_next = 1'b0;
                cot_next     = '0;
                cdone_next   = '0;
                rtime_next   = '0;
            end
            else
            begin
                rtime_next = rt_sat;
                if (CMP_W'(rt_sat) <= CMP_W'(end_w))
                begin
                    cyc_end_next = 1'b0;
                    if (CMP_W'(rt_sat) <= CMP_W'(on_time_reg) + CMP_W'(start_w))
                    begin
                        open_next = 1'b1;
                        cot_next  = cot_sat;
                    end
                    else
                    begin
                        open_next = 1'b0;
                        cot_next  = '0;
                    end
                end
                else if (last_hit)
                begin
                    // Burst over: drop everything, loop_end reads back as zero
                    run_en_next  = 1'b0;
                    open_next    = 1'b0;
                    cyc_end_next = 1'b0;
                    cot_next     = '0;
                    cdone_next   = '0;
                    rtime_next   = '0;
                end
                else
                begin
                    // Next cycle of the burst; skipped periods count as one
                    cyc_end_next = 1'b1;
                    open_next    = 1'b1;
                    cot_next     = cot_sat;
                    cdone_next   = cdone_reg + COUNT_WIDTH'(1);
                end
            end
        end
    end

    // Run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_en_reg  <= 1'b0;
            open_reg    <= 1'b0;
            cyc_end_reg <= 1'b0;
            cot_reg     <= '0;
            cdone_reg   <= '0;
            rtime_reg   <= '0;
        end
        else
        begin
            run_en_reg  <= run_en_next;
            open_reg    <= open_next;
            cyc_end_reg <= cyc_end_next;
            cot_reg     <= cot_next;
            cdone_reg   <= cdone_next;
            rtime_reg   <= rtime_next;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            res_reg.valve_open <= open_next;
            res_reg.enabled    <= run_en_next;
            res_reg.loop_end   <= cyc_end_next;
        end
    end

    // A tick on a disabled block leaves the run state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.kind == KIND_TICK && !run_en_reg)
        |=> (!open_reg && !cyc_end_reg && cot_reg == '0 && cdone_reg == '0))
        else $error("tick while disabled did not clear run state");

    // Open time only accumulates while the valve is open
    assert property (@(posedge clk) disable iff (!rst_n)
        (cot_reg != '0) |-> open_reg)
        else $error("continuous open time held with valve closed");

    // A passed cycle boundary always leaves a completed cycle counted
    assert property (@(posedge clk) disable iff (!rst_n)
        cyc_end_reg |-> (cdone_reg != '0))
        else $error("loop end flagged with no cycle counted");

    // Every word taken from the input register lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed word lost before the result register");

endmodule
